// ===== rtl/dpd_pkg.sv =====
`default_nettype none

package dpd_pkg;

    // framing characters
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
    localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'

    // payload limit, held to what the 10-bit count can reach
    localparam int MAX_PAYLOAD = 1023;
    localparam int LEN_W       = 10;
    localparam int LIMIT_MAX   = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LIMIT_COUNT =
        LEN_W'((MAX_PAYLOAD > LIMIT_MAX) ? LIMIT_MAX : MAX_PAYLOAD);

    // byte position that may carry the sequence separator
    localparam logic [LEN_W-1:0] SEQ_POS     = LEN_W'(2);
    localparam logic [LEN_W-1:0] SEQ_MIN_LEN = LEN_W'(3);

    // widths of the master-side data bus
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_HI   = 2'd2,
        PH_LO   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_ABORT   = 2'd3
    } kind_t;

    typedef struct packed {
        logic             has_sequence_prefix;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       ack_byte;
        logic [7:0]       data_byte;
        kind_t            kind;
    } result_t;

    // handshake between the input register and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } in_item_t;

    // hex digit value, all ones for a character that is not a hex digit
    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h57;
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h37;
            end else begin
                v = 8'hFF;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dpd_in_reg.sv =====
`default_nettype none

module dpd_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_byte,
    output dpd_pkg::in_item_t      item,
    input  wire logic              take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // register is free when empty or when its byte leaves this cycle, never in reset
    assign s_ready = aresetn && (!valid_reg || take);

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // captured byte
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/dpd_parse.sv =====
`default_nettype none

module dpd_parse (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dpd_pkg::in_item_t item,
    output logic               take,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dpd_pkg::result_t   out_res
);

    dpd_pkg::phase_t           phase_reg, phase_next;
    logic [7:0]                sum_reg, sum_next;
    logic [7:0]                high_reg, high_next;
    logic [dpd_pkg::LEN_W-1:0] count_reg, count_next;
    logic                      colon_reg, colon_next;
    logic                      out_valid_reg, out_valid_next;
    dpd_pkg::result_t          res_reg, res_next;
    logic                      load;
    logic [dpd_pkg::LEN_W-1:0] count_inc;
    logic [7:0]                digit;
    logic [7:0]                sent;
    logic [7:0]                c;

    // a byte moves on when the result register has room
    assign take      = item.valid && (!out_valid_reg || out_ready);
    assign c         = item.rx_byte;
    assign count_inc = count_reg + 1'b1;
    assign digit     = dpd_pkg::hex_val(c);
    assign sent      = high_reg + digit;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dpd_pkg::PH_IDLE;
            sum_reg       <= '0;
            high_reg      <= '0;
            count_reg     <= '0;
            colon_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            colon_reg     <= colon_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    // next state and result
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        high_next  = high_reg;
        count_next = count_reg;
        colon_next = colon_reg;
        load       = 1'b0;
        res_next   = '0;
        if (take) begin
            unique case (phase_reg)
                dpd_pkg::PH_IDLE: begin
                    if (c == dpd_pkg::CH_START) begin
                        phase_next = dpd_pkg::PH_DATA;
                        sum_next   = '0;
                        high_next  = '0;
                        count_next = '0;
                        colon_next = 1'b0;
                    end
                end
                dpd_pkg::PH_DATA: begin
                    if (c == dpd_pkg::CH_START) begin
                        // restart inside a packet abandons it
                        load                    = 1'b1;
                        res_next.kind           = dpd_pkg::KIND_ABORT;
                        res_next.payload_length = count_reg;
                        sum_next   = '0;
                        high_next  = '0;
                        count_next = '0;
                        colon_next = 1'b0;
                    end else if (c == dpd_pkg::CH_END) begin
                        phase_next = dpd_pkg::PH_HI;
                    end else begin
                        if (count_reg == dpd_pkg::SEQ_POS && c == dpd_pkg::CH_COLON) begin
                            colon_next = 1'b1;
                        end
                        sum_next   = sum_reg + c;
                        count_next = count_inc;
                        load       = 1'b1;
                        if (count_inc >= dpd_pkg::LIMIT_COUNT) begin
                            // limit reached, packet dropped
                            phase_next              = dpd_pkg::PH_IDLE;
                            res_next.kind           = dpd_pkg::KIND_ABORT;
                            res_next.payload_length = count_inc;
                        end else begin
                            res_next.kind      = dpd_pkg::KIND_PAYLOAD;
                            res_next.data_byte = c;
                        end
                    end
                end
                dpd_pkg::PH_HI: begin
                    high_next  = {digit[3:0], 4'h0};
                    phase_next = dpd_pkg::PH_LO;
                end
                dpd_pkg::PH_LO: begin
                    phase_next              = dpd_pkg::PH_IDLE;
                    load                    = 1'b1;
                    res_next.payload_length = count_reg;
                    if (sent == sum_reg) begin
                        res_next.kind     = dpd_pkg::KIND_GOOD;
                        res_next.ack_byte = dpd_pkg::CH_ACK;
                        res_next.has_sequence_prefix =
                            (count_reg >= dpd_pkg::SEQ_MIN_LEN) && colon_reg;
                    end else begin
                        res_next.kind     = dpd_pkg::KIND_BAD;
                        res_next.ack_byte = dpd_pkg::CH_NAK;
                    end
                end
                default: begin
                    phase_next = dpd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result register fills on load, empties on a completed transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // no byte is consumed over a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |-> !take)
        else $error("byte consumed while result stalled");

    // count stays below the limit while collecting payload
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == dpd_pkg::PH_DATA |-> count_reg < dpd_pkg::LIMIT_COUNT)
        else $error("payload count passed limit");

    // a checksum verdict ends the packet
    a_verdict_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (res_next.kind == dpd_pkg::KIND_GOOD || res_next.kind == dpd_pkg::KIND_BAD)
        |=> phase_reg == dpd_pkg::PH_IDLE)
        else $error("verdict did not end packet");

    // sequence flag only on a good packet
    a_seq_good: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.has_sequence_prefix |-> res_reg.kind == dpd_pkg::KIND_GOOD)
        else $error("sequence flag on non-good result");

endmodule

`default_nettype wire

// ===== rtl/debug_packet_deframer.sv =====
`default_nettype none

// Deframes the remote-debug serial packet format: '$' payload '#' hh. Takes
// one byte per clock on the slave side and gives at most one result per byte
// on the master side, through the input register and then the result
// register; one byte is accepted every cycle while results are taken.
// Payload bytes come out as they arrive (tuser payload); after the two
// checksum digits a good (ack '+') or bad (ack '-') result carries the length
// and the sequence-prefix flag. A '$' inside a payload, or reaching the
// payload limit, gives an abandoned result.
module debug_packet_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] data_byte, [15:8] ack_byte, [25:16] payload_length,
    // [26] has_sequence_prefix, [31:27] zero
    output logic [dpd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [dpd_pkg::TUSER_W-1:0] m_axis_tuser    // [1:0] kind
);

    dpd_pkg::in_item_t item;
    dpd_pkg::result_t  res;
    logic              take;

    // input register
    dpd_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_byte  (s_axis_tdata),
        .item    (item),
        .take    (take)
    );

    // parser and result register
    dpd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack result fields
    assign m_axis_tdata = {5'b0, res.has_sequence_prefix, res.payload_length,
                           res.ack_byte, res.data_byte};
    assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire
